// ===== rtl/core/xmcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// XMODEM-1K CRC receiver package
// Shared types, codes and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package xmcrc_pkg;

    localparam int LongBlockBytes  = 1024;
    localparam int ShortBlockBytes = 128;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_NUM1 = 3'd2;
    localparam logic [2:0] PH_NUM2 = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_TOUT = 3'd6;
    localparam logic [2:0] PH_CANC = 3'd7;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [2:0] REG_EXPECTED = 3'd0;
    localparam logic [2:0] REG_HDR_TO   = 3'd1;
    localparam logic [2:0] REG_NUM_TO   = 3'd2;
    localparam logic [2:0] REG_BLK_TO   = 3'd3;
    localparam logic [2:0] REG_RETRY    = 3'd4;

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_COMMIT  = 2'd1;
    localparam logic [1:0] VERDICT_DISCARD = 2'd2;

    // One classified request from the front part.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_req;

    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  data_offset;
        logic        data_keep;
        logic [1:0]  block_verdict;
        logic [10:0] commit_length;
        logic [24:0] bytes_done;
        logic [2:0]  status;
    } t_res;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/xmodem_1k_crc_receiver.sv =====
// ----------------------------------------------------------------------------
// XMODEM-1K CRC-16 receiver
// Receives one XMODEM transfer in CRC mode and streams tentative payload.
// ----------------------------------------------------------------------------
// Usage: each input request carries a kind (start, received byte, or one
// millisecond tick) and a byte. Every input request yields exactly one
// result request on the master side, carrying the reply byte, any
// tentative payload byte with its offset and keep flag, a commit or
// discard verdict, the committed byte count and the transfer status.
// A request of the unused kind 3 changes nothing; its result only reports
// the committed byte count and the status.
// A request passes through the queue and then the engine's result register
// before its result is offered on the master side.
// Throughput: one request per cycle while tready is high; the engine step,
// a byte-wise CRC-16 update plus 25-bit adds and compares, sets that rate.
// A two-entry queue separates the front end from the engine, and the
// engine's output register takes the next request as the waiting result is
// taken; while the sink holds tready low the queue accepts until full.
// Reset (synchronous, active low) empties the queue, clears the transfer
// state to idle and loads the default timeouts and retry limit.
// Configuration writes take effect at once and are meant to be made only
// while no request is in flight.
// ----------------------------------------------------------------------------
module xmodem_1k_crc_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] reply_valid, [8:1] reply_byte, [9] data_valid, [17:10] data_byte,
    // [27:18] data_offset, [28] data_keep, [30:29] block_verdict,
    // [41:31] commit_length, [66:42] bytes_done, [69:67] status, rest zero
    output logic [71:0] m_axis_tdata
);
    xmcrc_pkg::t_req req_in, req_q;
    xmcrc_pkg::t_res res;
    logic            q_valid, q_ready;

    assign req_in.kind    = s_axis_tuser;
    assign req_in.rx_byte = s_axis_tdata;

    xmcrc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(req_in),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(req_q)
    );

    xmcrc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(req_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {2'b00, res.status, res.bytes_done, res.commit_length,
                           res.block_verdict, res.data_keep, res.data_offset,
                           res.data_byte, res.data_valid, res.reply_byte,
                           res.reply_valid};

    // A result never shows both a commit and tentative payload data.
    a_no_commit_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(res.data_valid && res.block_verdict == xmcrc_pkg::VERDICT_COMMIT))
        else $error("commit together with payload byte");

    // A commit always goes with an ACK reply.
    a_commit_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.block_verdict == xmcrc_pkg::VERDICT_COMMIT) |->
        (res.reply_valid && res.reply_byte == xmcrc_pkg::CH_ACK))
        else $error("commit without ACK");

    // Commit length never exceeds a long block.
    a_commit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.commit_length <= 11'd1024))
        else $error("commit length out of range");
endmodule

// ===== rtl/core/xmcrc_front.sv =====
// ----------------------------------------------------------------------------
// XMODEM receiver front end
// Accepts input requests and queues them for the protocol engine.
// ----------------------------------------------------------------------------
module xmcrc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  xmcrc_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output xmcrc_pkg::t_req  o_req
);
    // Two-entry queue so that the back part may stall independently.
    xmcrc_pkg::t_req r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_q[r_wp] <= i_req;
    end
endmodule

// ===== rtl/core/xmcrc_back.sv =====
// ----------------------------------------------------------------------------
// XMODEM receiver protocol engine
// Runs the transfer state machine and registers one result per request.
// ----------------------------------------------------------------------------
module xmcrc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [24:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  xmcrc_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output xmcrc_pkg::t_res  o_res
);
    logic [24:0] r_exp;
    logic [15:0] r_hto, r_nto, r_bto;
    logic [7:0]  r_rlim;

    logic [2:0]  r_ph, n_ph;
    logic [7:0]  r_nbn, n_nbn, r_rc, n_rc, r_gbn, n_gbn;
    logic [24:0] r_ct, n_ct;
    logic [15:0] r_tt, n_tt, r_crc, n_crc, r_scrc, n_scrc;
    logic        r_long, n_long;
    logic [10:0] r_bi, n_bi;

    logic            r_ov;
    xmcrc_pkg::t_res r_res, n_res;
    logic            take;

    logic [10:0] bsize;
    logic [16:0] tnext;
    logic [15:0] tlim;
    logic        texp;
    logic [15:0] full_crc;
    logic [24:0] room, w;
    logic [24:0] ct_w;
    logic [25:0] keep_sum;

    assign o_ready = !r_ov || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    assign bsize = r_long ? 11'(xmcrc_pkg::LongBlockBytes) : 11'(xmcrc_pkg::ShortBlockBytes);
    assign tnext = {1'b0, r_tt} + 17'd1;

    always_comb begin
        tlim = r_bto;
        priority if (r_ph == xmcrc_pkg::PH_HDR) tlim = r_hto;
        else if (r_ph == xmcrc_pkg::PH_NUM1 || r_ph == xmcrc_pkg::PH_NUM2) tlim = r_nto;
    end
    assign texp     = tnext >= {1'b0, tlim};
    assign full_crc = {r_scrc[15:8], i_req.rx_byte};
    assign room     = (r_ct < r_exp) ? (r_exp - r_ct) : 25'd0;
    assign w        = ({14'd0, bsize} < room) ? {14'd0, bsize} : room;
    assign ct_w     = r_ct + w;
    assign keep_sum = {1'b0, r_ct} + {15'd0, r_bi};

    always_comb begin
        n_ph = r_ph; n_nbn = r_nbn; n_ct = r_ct; n_rc = r_rc; n_tt = r_tt;
        n_long = r_long; n_bi = r_bi; n_crc = r_crc; n_scrc = r_scrc; n_gbn = r_gbn;
        n_res = '0;
        unique case (i_req.kind)
            xmcrc_pkg::KIND_START: begin
                if (r_ph == xmcrc_pkg::PH_DATA && r_bi != 11'd0)
                    n_res.block_verdict = xmcrc_pkg::VERDICT_DISCARD;
                n_nbn = 8'd1; n_ct = '0; n_rc = '0; n_tt = '0; n_long = 1'b0;
                n_bi = '0; n_crc = '0; n_scrc = '0; n_gbn = '0;
                n_res.reply_valid = 1'b1;
                n_res.reply_byte  = xmcrc_pkg::CH_C;
                n_ph = (r_exp == 25'd0) ? xmcrc_pkg::PH_DONE : xmcrc_pkg::PH_HDR;
            end
            xmcrc_pkg::KIND_TICK: begin
                if (r_ph == xmcrc_pkg::PH_HDR || r_ph == xmcrc_pkg::PH_NUM1 ||
                    r_ph == xmcrc_pkg::PH_NUM2 || r_ph == xmcrc_pkg::PH_DATA) begin
                    n_tt = texp ? 16'd0 : tnext[15:0];
                    if (texp) begin
                        n_res.reply_valid = 1'b1;
                        n_res.reply_byte  = xmcrc_pkg::CH_NAK;
                        if (r_ph == xmcrc_pkg::PH_HDR) begin
                            if (r_rc >= r_rlim) begin
                                n_res.reply_byte = xmcrc_pkg::CH_CAN;
                                n_ph = xmcrc_pkg::PH_TOUT;
                            end else begin
                                n_rc = r_rc + 8'd1;
                            end
                        end else begin
                            if (r_ph == xmcrc_pkg::PH_DATA && r_bi != 11'd0)
                                n_res.block_verdict = xmcrc_pkg::VERDICT_DISCARD;
                            n_ph = xmcrc_pkg::PH_HDR;
                        end
                    end
                end
            end
            xmcrc_pkg::KIND_BYTE: begin
                if (r_ph == xmcrc_pkg::PH_HDR) begin
                    n_tt = '0;
                    priority if (i_req.rx_byte == xmcrc_pkg::CH_EOT) begin
                        n_res.reply_valid = 1'b1;
                        n_res.reply_byte  = xmcrc_pkg::CH_ACK;
                        n_ph = xmcrc_pkg::PH_DONE;
                    end else if (i_req.rx_byte == xmcrc_pkg::CH_CAN) begin
                        n_ph = xmcrc_pkg::PH_CANC;
                    end else if (i_req.rx_byte == xmcrc_pkg::CH_SOH ||
                                 i_req.rx_byte == xmcrc_pkg::CH_STX) begin
                        n_long = (i_req.rx_byte == xmcrc_pkg::CH_STX);
                        n_ph = xmcrc_pkg::PH_NUM1;
                    end else begin
                        n_res.reply_valid = 1'b1;
                        n_res.reply_byte  = xmcrc_pkg::CH_NAK;
                    end
                end else if (r_ph == xmcrc_pkg::PH_NUM1) begin
                    n_tt = '0; n_gbn = i_req.rx_byte; n_ph = xmcrc_pkg::PH_NUM2;
                end else if (r_ph == xmcrc_pkg::PH_NUM2) begin
                    n_tt = '0;
                    if (r_gbn == r_nbn && i_req.rx_byte == ~r_nbn) begin
                        n_bi = '0; n_crc = '0; n_scrc = '0; n_ph = xmcrc_pkg::PH_DATA;
                    end else begin
                        n_res.reply_valid = 1'b1;
                        n_res.reply_byte  = xmcrc_pkg::CH_NAK;
                        n_ph = xmcrc_pkg::PH_HDR;
                    end
                end else if (r_ph == xmcrc_pkg::PH_DATA) begin
                    priority if (r_bi < bsize) begin
                        n_res.data_valid  = 1'b1;
                        n_res.data_byte   = i_req.rx_byte;
                        n_res.data_offset = r_bi[9:0];
                        n_res.data_keep   = keep_sum < {1'b0, r_exp};
                        n_crc = xmcrc_pkg::crc_step(r_crc, i_req.rx_byte);
                        n_bi  = r_bi + 11'd1;
                    end else if (r_bi == bsize) begin
                        n_scrc = {i_req.rx_byte, 8'h00};
                        n_bi   = r_bi + 11'd1;
                    end else begin
                        n_scrc = full_crc;
                        n_res.reply_valid = 1'b1;
                        n_tt = '0; n_bi = '0;
                        if (full_crc != r_crc) begin
                            n_res.reply_byte    = xmcrc_pkg::CH_NAK;
                            n_res.block_verdict = xmcrc_pkg::VERDICT_DISCARD;
                            n_ph = xmcrc_pkg::PH_HDR;
                        end else begin
                            n_ct  = ct_w;
                            n_nbn = r_nbn + 8'd1;
                            n_rc  = '0;
                            n_res.reply_byte    = xmcrc_pkg::CH_ACK;
                            n_res.block_verdict = xmcrc_pkg::VERDICT_COMMIT;
                            n_res.commit_length = w[10:0];
                            n_ph = (ct_w >= r_exp) ? xmcrc_pkg::PH_DONE : xmcrc_pkg::PH_HDR;
                        end
                    end
                end
            end
            default: ;
        endcase
        n_res.bytes_done = n_ct;
        unique case (n_ph)
            xmcrc_pkg::PH_IDLE: n_res.status = 3'd0;
            xmcrc_pkg::PH_DONE: n_res.status = 3'd2;
            xmcrc_pkg::PH_TOUT: n_res.status = 3'd3;
            xmcrc_pkg::PH_CANC: n_res.status = 3'd4;
            default:            n_res.status = 3'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0; r_hto <= 16'd10000; r_nto <= 16'd1000; r_bto <= 16'd5000;
            r_rlim <= 8'd10;
            r_ph <= xmcrc_pkg::PH_IDLE; r_nbn <= 8'd1; r_ct <= '0; r_rc <= '0;
            r_tt <= '0; r_long <= 1'b0; r_bi <= '0; r_crc <= '0; r_scrc <= '0;
            r_gbn <= '0; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    xmcrc_pkg::REG_EXPECTED: r_exp  <= i_cfg_data;
                    xmcrc_pkg::REG_HDR_TO:   r_hto  <= i_cfg_data[15:0];
                    xmcrc_pkg::REG_NUM_TO:   r_nto  <= i_cfg_data[15:0];
                    xmcrc_pkg::REG_BLK_TO:   r_bto  <= i_cfg_data[15:0];
                    xmcrc_pkg::REG_RETRY:    r_rlim <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (take) begin
                r_ph <= n_ph; r_nbn <= n_nbn; r_ct <= n_ct; r_rc <= n_rc; r_tt <= n_tt;
                r_long <= n_long; r_bi <= n_bi; r_crc <= n_crc; r_scrc <= n_scrc;
                r_gbn <= n_gbn;
            end
            if (take) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        if (take) r_res <= n_res;
    end
endmodule
